// ----- rtl/core/lbcd_pkg.sv -----
// Shared types and constants of the block cache directory.
// Item structs, command and state codes, control groups between modules.
// No dependencies.
package lbcd_pkg;

   localparam int ID_W       = 8;
   localparam int SLOT_OUT_W = 6;
   localparam int USED_OUT_W = 9;
   localparam int CNT_W      = 32;
   localparam int CHUNK_W    = 16;
   localparam int CHUNK_LOG  = 4;
   localparam int CSR_IDX_W  = 1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CACHING  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_ALLOC = 1'd1;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_ALLOC  = 2'd2,
      CMD_FREE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_EVAL,
      ST_UPDATE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      cmd_type         command;
      logic [ID_W-1:0] block_id;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  fetch_needed;
      logic                  evict_valid;
      logic [ID_W-1:0]       evict_block;
      logic                  direct_store;
      logic [ID_W-1:0]       alloc_block;
      logic                  alloc_fail;
      logic [USED_OUT_W-1:0] used_count;
      logic [CNT_W-1:0]      request_count;
      logic [CNT_W-1:0]      fault_count;
   } rsp_type;

   // per-cell control of the directory chain
   typedef struct packed {
      logic cmp;    // register key match
      logic shift;  // take the left neighbor's entry
      logic claim;  // write key in place, mark valid
      logic drop;   // mark empty in place
   } cell_ctrl_type;

   // free bitmap control and status
   typedef struct packed {
      logic            start;
      logic            apply;
      logic            grant_req;
      logic            free_req;
      logic [ID_W-1:0] block_id;
   } fm_ctrl_type;

   typedef struct packed {
      logic                  done;
      logic                  found;
      logic                  in_range;
      logic [ID_W-1:0]       block;
      logic [USED_OUT_W-1:0] used;
   } fm_status_type;

endpackage

// ----- rtl/core/lbcd_cell.sv -----
// One directory entry of the recency chain: block id, valid bit, slot.
// Shifts from its left neighbor, claims or empties in place, registers a match.
// Depends on lbcd_pkg.
module lbcd_cell #(
   parameter int INDEX  = 0,
   parameter int SLOT_W = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lbcd_pkg::cell_ctrl_type      ctrl,
   input  logic [lbcd_pkg::ID_W-1:0]    key,
   input  logic [lbcd_pkg::ID_W-1:0]    left_block,
   input  logic                         left_valid,
   input  logic [SLOT_W-1:0]            left_slot,
   output logic [lbcd_pkg::ID_W-1:0]    block,
   output logic                         valid,
   output logic [SLOT_W-1:0]            slot,
   output logic                         match
);
   import lbcd_pkg::*;

   logic [ID_W-1:0]   block_ff;
   logic              valid_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              match_ff;

   // entry state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= SLOT_W'(INDEX);
         match_ff <= 1'b0;
      end else begin
         if (ctrl.cmp) begin
            match_ff <= valid_ff && (block_ff == key);
         end
         if (ctrl.shift) begin
            valid_ff <= left_valid;
            slot_ff  <= left_slot;
         end else if (ctrl.claim) begin
            valid_ff <= 1'b1;
         end else if (ctrl.drop) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // block id needs no reset: only read behind the valid bit
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         block_ff <= left_block;
      end else if (ctrl.claim) begin
         block_ff <= key;
      end
   end

   assign block = block_ff;
   assign valid = valid_ff;
   assign slot  = slot_ff;
   assign match = match_ff;

endmodule

// ----- rtl/core/lbcd_free_map.sv -----
// Free-block bitmap with lowest-clear-bit scanner and in-use counter.
// Scans one 16-bit word per cycle; grant and release apply on the result edge.
// Depends on lbcd_pkg.
module lbcd_free_map #(
   parameter int BLOCKS = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lbcd_pkg::fm_ctrl_type   ctrl,
   output lbcd_pkg::fm_status_type status
);
   import lbcd_pkg::*;

   localparam int NCHUNK_RAW = (BLOCKS + CHUNK_W - 1) / CHUNK_W;
   localparam int NCHUNK     = (NCHUNK_RAW < 2) ? 2 : NCHUNK_RAW;
   localparam int CHK_W      = $clog2(NCHUNK);
   localparam int PAD_W      = NCHUNK * CHUNK_W;
   localparam int FIDX_W     = CHK_W + CHUNK_LOG;
   localparam int CNT_BW     = $clog2(BLOCKS + 1);
   localparam int RW         = (CNT_BW > ID_W) ? CNT_BW : ID_W;

   logic [BLOCKS-1:0]  used_ff;
   logic [CNT_BW-1:0]  count_ff;
   logic [CHK_W-1:0]   chunk_ff;
   logic               active_ff;
   logic               done_ff;
   logic               found_ff;
   logic [FIDX_W-1:0]  fidx_ff;

   logic [PAD_W-1:0]   padded;
   logic [CHUNK_W-1:0] words [NCHUNK];
   logic [CHUNK_W-1:0] word;
   logic               word_free;
   logic [CHUNK_LOG-1:0] pe;
   logic               last_chunk;
   logic [BLOCKS-1:0]  rel_oh;
   logic [BLOCKS-1:0]  grant_oh;
   logic               was_set;
   logic               do_grant;
   logic               do_rel;
   logic [CNT_BW-1:0]  count_in;
   logic [FIDX_W+ID_W-1:0]       fidx_wide;
   logic [CNT_BW+USED_OUT_W-1:0] count_wide;

   // bits past BLOCKS read as used
   always_comb begin
      padded = '1;
      padded[BLOCKS-1:0] = used_ff;
   end

   for (genvar c = 0; c < NCHUNK; c++) begin : g_word
      assign words[c] = padded[c*CHUNK_W +: CHUNK_W];
   end

   // lowest clear bit of the current word
   always_comb begin
      word      = words[chunk_ff];
      word_free = ~&word;
      pe        = '0;
      for (int c = CHUNK_W - 1; c >= 0; c--) begin
         if (!word[c]) begin
            pe = CHUNK_LOG'(c);
         end
      end
      last_chunk = (chunk_ff == CHK_W'(NCHUNK - 1));
   end

   // release and grant decode
   always_comb begin
      for (int b = 0; b < BLOCKS; b++) begin
         rel_oh[b]   = (RW'(ctrl.block_id) == RW'(b));
         grant_oh[b] = (fidx_ff == FIDX_W'(b));
      end
      was_set  = |(used_ff & rel_oh);
      do_grant = ctrl.grant_req & found_ff;
      do_rel   = ctrl.free_req & was_set;
      count_in = count_ff + CNT_BW'(do_grant) - CNT_BW'(do_rel);
   end

   // bitmap and counter
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= BLOCKS'(1);
         count_ff <= CNT_BW'(1);
      end else if (ctrl.apply) begin
         used_ff  <= (used_ff | (grant_oh & {BLOCKS{do_grant}}))
                     & ~(rel_oh & {BLOCKS{ctrl.free_req}});
         count_ff <= count_in;
      end
   end

   // word-serial scan
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff  <= '0;
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         found_ff  <= 1'b0;
      end else if (ctrl.start) begin
         chunk_ff  <= '0;
         active_ff <= 1'b1;
         done_ff   <= 1'b0;
         found_ff  <= 1'b0;
      end else if (active_ff) begin
         if (word_free) begin
            found_ff  <= 1'b1;
            active_ff <= 1'b0;
            done_ff   <= 1'b1;
         end else if (last_chunk) begin
            active_ff <= 1'b0;
            done_ff   <= 1'b1;
         end else begin
            chunk_ff <= chunk_ff + CHK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (active_ff && word_free) begin
         fidx_ff <= {chunk_ff, pe};
      end
   end

   assign fidx_wide  = (FIDX_W + ID_W)'(fidx_ff);
   assign count_wide = (CNT_BW + USED_OUT_W)'(count_in);

   assign status.done     = done_ff;
   assign status.found    = found_ff;
   assign status.in_range = |rel_oh;
   assign status.block    = fidx_wide[ID_W-1:0];
   assign status.used     = count_wide[USED_OUT_W-1:0];

endmodule

// ----- rtl/core/lru_block_cache_directory.sv -----
// Block cache directory: recency-ordered chain of entry cells plus free-block bitmap.
// Request channel req_valid/req_stall/req_data carries a command and block id;
// response channel rsp_valid/rsp_stall/rsp_data returns one item per request.
// Configuration writes on csr_valid/csr_ready/csr_index/csr_data, always ready,
// to be issued only while no request is in flight.
// Lookup, write and free pass match, evaluate and update steps: the response is
// registered at the update step, and the next item is taken only once that step
// is done. Allocate scans the bitmap one 16-bit word per cycle, up to and including
// the first word with a clear bit, or through every word when the bitmap is full.
// One item is worked on at a time; req_stall is high while one is in flight.
// The response sits in an output register; a finished item waits there while
// rsp_stall is high and the block still accepts the next request, holding its
// own result step until the register frees.
// Synchronous reset empties the directory, sets slot i at position i, marks only
// block 0 in use, clears counters and both configuration bits.
// Depends on lbcd_pkg, lbcd_cell, lbcd_free_map.
module lru_block_cache_directory #(
   parameter int BLOCKS  = 256,
   parameter int ENTRIES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  lbcd_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lbcd_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lbcd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic                             csr_data
);
   import lbcd_pkg::*;

   localparam int E      = ENTRIES;
   localparam int SLOT_W = $clog2(ENTRIES);

   state_type state_ff, state_in;
   cmd_type   cmd_ff;
   logic [ID_W-1:0] id_ff;
   logic caching_ff;
   logic no_alloc_ff;
   logic [CNT_W-1:0] req_cnt_ff, req_cnt_in;
   logic [CNT_W-1:0] fault_cnt_ff, fault_cnt_in;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   logic accept;
   logic out_free;
   logic upd;

   // chain signals
   cell_ctrl_type     cctl [E];
   logic [ID_W-1:0]   block_arr [E];
   logic [SLOT_W-1:0] slot_arr [E];
   logic [E-1:0]      valid_vec;
   logic [E-1:0]      match_vec;
   logic [SLOT_W-1:0] sel_slot;

   // evaluation results
   logic [E-1:0] hit_oh, hmask, rv, rv_up, below_last, mmask, q_oh, wvec, f_oh;
   logic [E-1:0] sel_in, shift_in, claim_in, drop_in;
   logic         found_in, placed_in, whit_in;
   logic [E-1:0] sel_ff, shift_ff, claim_ff, drop_ff;
   logic         found_ff, placed_ff, whit_ff;

   fm_ctrl_type   fm_ctrl;
   fm_status_type fm_status;
   logic [SLOT_W+SLOT_OUT_W-1:0] slot_wide;

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign upd       = (state_ff == ST_UPDATE) && out_free;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         caching_ff  <= 1'b0;
         no_alloc_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CACHING:  caching_ff  <= csr_data;
            CSR_NO_ALLOC: no_alloc_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.command == CMD_ALLOC) ? ST_SCAN : ST_MATCH;
            end
         end
         ST_MATCH:  state_in = ST_EVAL;
         ST_EVAL:   state_in = ST_UPDATE;
         ST_SCAN: begin
            if (fm_status.done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_data.command;
         id_ff  <= req_data.block_id;
      end
   end

   // cell chain; cell 0 takes the new front entry
   for (genvar i = 0; i < E; i++) begin : g_cell
      logic [ID_W-1:0]   lb;
      logic              lv;
      logic [SLOT_W-1:0] ls;

      if (i == 0) begin : g_front
         assign lb = id_ff;
         assign lv = 1'b1;
         assign ls = sel_slot;
      end else begin : g_link
         assign lb = block_arr[i-1];
         assign lv = valid_vec[i-1];
         assign ls = slot_arr[i-1];
      end

      assign cctl[i].cmp   = (state_ff == ST_MATCH);
      assign cctl[i].shift = upd & shift_ff[i];
      assign cctl[i].claim = upd & claim_ff[i];
      assign cctl[i].drop  = upd & drop_ff[i] & fm_status.in_range;

      lbcd_cell #(
         .INDEX  (i),
         .SLOT_W (SLOT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cctl[i]),
         .key        (id_ff),
         .left_block (lb),
         .left_valid (lv),
         .left_slot  (ls),
         .block      (block_arr[i]),
         .valid      (valid_vec[i]),
         .slot       (slot_arr[i]),
         .match      (match_vec[i])
      );

      assign rv[i] = valid_vec[E-1-i];
      assign below_last[i] = rv_up[E-1-i];
   end

   // positions up to the last valid entry, in reversed order
   assign rv_up = rv | (~rv + E'(1));

   // first match, last valid, first free place
   always_comb begin
      hit_oh = match_vec & (~match_vec + E'(1));
      hmask  = ~(match_vec | (~match_vec + E'(1))) | hit_oh;
      mmask  = {below_last[E-2:0], 1'b1};
      mmask[1] = 1'b1;
      q_oh   = mmask & ~{1'b0, mmask[E-1:1]};
      wvec   = match_vec | (~valid_vec & {E{~no_alloc_ff}});
      f_oh   = wvec & (~wvec + E'(1));
   end

   always_comb begin
      sel_in    = '0;
      shift_in  = '0;
      claim_in  = '0;
      drop_in   = '0;
      found_in  = 1'b0;
      placed_in = 1'b0;
      whit_in   = 1'b0;
      if (caching_ff) begin
         case (cmd_ff)
            CMD_LOOKUP: begin
               if (|match_vec) begin
                  found_in = 1'b1;
                  sel_in   = hit_oh;
                  shift_in = hmask;
               end else if (!no_alloc_ff) begin
                  sel_in   = q_oh;
                  shift_in = mmask;
               end
            end
            CMD_WRITE: begin
               sel_in    = f_oh;
               claim_in  = f_oh & ~valid_vec;
               placed_in = |wvec;
               whit_in   = |(f_oh & match_vec);
            end
            CMD_FREE:  drop_in = match_vec;
            default: ;
         endcase
      end
   end

   // an allocate skips evaluation, so its start clears the chain controls
   always_ff @(posedge clock) begin
      if (state_ff == ST_EVAL) begin
         sel_ff    <= sel_in;
         shift_ff  <= shift_in;
         claim_ff  <= claim_in;
         drop_ff   <= drop_in;
         found_ff  <= found_in;
         placed_ff <= placed_in;
         whit_ff   <= whit_in;
      end else if (fm_ctrl.start) begin
         sel_ff    <= '0;
         shift_ff  <= '0;
         claim_ff  <= '0;
         drop_ff   <= '0;
      end
   end

   // slot of the selected cell
   always_comb begin
      sel_slot = '0;
      for (int i = 0; i < E; i++) begin
         sel_slot = sel_slot | (slot_arr[i] & {SLOT_W{sel_ff[i]}});
      end
   end

   assign slot_wide = (SLOT_W + SLOT_OUT_W)'(sel_slot);

   // free bitmap
   assign fm_ctrl.start     = accept && (req_data.command == CMD_ALLOC);
   assign fm_ctrl.apply     = upd;
   assign fm_ctrl.grant_req = (cmd_ff == CMD_ALLOC);
   assign fm_ctrl.free_req  = (cmd_ff == CMD_FREE);
   assign fm_ctrl.block_id  = id_ff;

   lbcd_free_map #(
      .BLOCKS (BLOCKS)
   ) u_free_map (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (fm_ctrl),
      .status (fm_status)
   );

   // result item
   always_comb begin
      rsp_data_in = '0;
      req_cnt_in   = req_cnt_ff;
      fault_cnt_in = fault_cnt_ff;
      case (cmd_ff)
         CMD_LOOKUP: begin
            if (!caching_ff) begin
               rsp_data_in.fetch_needed = 1'b1;
            end else begin
               req_cnt_in = req_cnt_ff + CNT_W'(1);
               if (found_ff) begin
                  rsp_data_in.hit  = 1'b1;
                  rsp_data_in.slot = slot_wide[SLOT_OUT_W-1:0];
               end else begin
                  fault_cnt_in = fault_cnt_ff + CNT_W'(1);
                  rsp_data_in.fetch_needed = 1'b1;
                  if (!no_alloc_ff) begin
                     rsp_data_in.slot        = slot_wide[SLOT_OUT_W-1:0];
                     rsp_data_in.evict_valid = valid_vec[E-1];
                     rsp_data_in.evict_block = valid_vec[E-1] ? block_arr[E-1] : '0;
                  end
               end
            end
         end
         CMD_WRITE: begin
            if (caching_ff && placed_ff) begin
               rsp_data_in.hit  = whit_ff;
               rsp_data_in.slot = slot_wide[SLOT_OUT_W-1:0];
            end else begin
               rsp_data_in.direct_store = 1'b1;
            end
         end
         CMD_ALLOC: begin
            if (fm_status.found) begin
               rsp_data_in.alloc_block = fm_status.block;
            end else begin
               rsp_data_in.alloc_fail = 1'b1;
            end
         end
         default: ;
      endcase
      rsp_data_in.used_count    = fm_status.used;
      rsp_data_in.request_count = req_cnt_in;
      rsp_data_in.fault_count   = fault_cnt_in;
   end

   // counters and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_cnt_ff   <= '0;
         fault_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (upd) begin
         req_cnt_ff   <= req_cnt_in;
         fault_cnt_ff <= fault_cnt_in;
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (upd) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a response only appears after an update step
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("response without update step");

   // at most one cell supplies the result slot
   a_sel_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> $onehot0(sel_ff))
      else $error("slot select not one-hot");

   // any shift of the chain includes the front cell
   a_shift_front: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_UPDATE) && (|shift_ff)) |-> shift_ff[0])
      else $error("chain shift without front cell");
`endif

endmodule
